// File: hw/rtl/swmm_pkg.sv
// Package for the sliding-window minimum and maximum block.
// Holds the widths, the identity values of the compare chain and the shared types.
// No dependencies.
`default_nettype none
package swmm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SMP_W      = 32;
  localparam int WIN_W      = 7;
  localparam int IDX_W      = $clog2(WINDOW_MAX);

  localparam logic signed [SMP_W-1:0] SMP_POS_LIMIT = 32'sh7FFF_FFFF;
  localparam logic signed [SMP_W-1:0] SMP_NEG_LIMIT = 32'sh8000_0000;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic signed [SMP_W-1:0] lo;
    logic signed [SMP_W-1:0] hi;
  } swmm_link_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SWEEP
  } swmm_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/swmm_cell.sv
// One cell of the window chain: a stored sample plus running minimum and maximum.
// Depends on swmm_pkg.
`default_nettype none
module swmm_cell (
  input  wire logic               clk,
  input  wire logic               shift_en,
  input  wire swmm_pkg::swmm_link_t link_in,
  output swmm_pkg::swmm_link_t      link_out
);

  logic signed [swmm_pkg::SMP_W-1:0] smp_r;
  logic signed [swmm_pkg::SMP_W-1:0] lo_r;
  logic signed [swmm_pkg::SMP_W-1:0] hi_r;
  logic signed [swmm_pkg::SMP_W-1:0] lo_nxt;
  logic signed [swmm_pkg::SMP_W-1:0] hi_nxt;

  always_comb begin
    lo_nxt = ($signed(smp_r) < $signed(link_in.lo)) ? smp_r : link_in.lo;
    hi_nxt = ($signed(smp_r) > $signed(link_in.hi)) ? smp_r : link_in.hi;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      smp_r <= link_in.smp;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign link_out.smp = smp_r;
  assign link_out.lo  = lo_r;
  assign link_out.hi  = hi_r;

endmodule
`default_nettype wire

// File: hw/rtl/swmm_chain.sv
// Row of window cells, newest sample in cell 0, with the tap at the window end.
// Depends on swmm_pkg and swmm_cell.
`default_nettype none
module swmm_chain (
  input  wire logic                              clk,
  input  wire logic                              shift_en,
  input  wire logic signed [swmm_pkg::SMP_W-1:0] sample_in,
  input  wire logic        [swmm_pkg::IDX_W-1:0] tap_idx,
  output logic signed      [swmm_pkg::SMP_W-1:0] tap_lo,
  output logic signed      [swmm_pkg::SMP_W-1:0] tap_hi
);

  swmm_pkg::swmm_link_t links [swmm_pkg::WINDOW_MAX+1];
  logic [swmm_pkg::IDX_W:0] tap_sel;

  assign links[0].smp = sample_in;
  assign links[0].lo  = swmm_pkg::SMP_POS_LIMIT;
  assign links[0].hi  = swmm_pkg::SMP_NEG_LIMIT;

  for (genvar g = 0; g < swmm_pkg::WINDOW_MAX; g++) begin : g_cell
    swmm_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  assign tap_sel = {1'b0, tap_idx} + {{swmm_pkg::IDX_W{1'b0}}, 1'b1};

  always_comb begin
    tap_lo = links[tap_sel].lo;
    tap_hi = links[tap_sel].hi;
  end

endmodule
`default_nettype wire

// File: hw/rtl/sliding_window_min_max.sv
// Sweep: an item that completes a window starts a sweep in which the minimum and maximum
// ripple one cell per cycle down the chain to the tap at the effective window size w.
// The input is not ready during the sweep, so no new sample is taken until the result is issued.
// Reset clears the control state, the sample count and sets the window size to one;
// the stored samples are not cleared and are never read before being written.
// Depends on swmm_pkg and swmm_chain.
`default_nettype none
module sliding_window_min_max (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic signed [swmm_pkg::SMP_W-1:0] in_tdata,  // [31:0] sample
  input  wire logic                              in_tuser,  // [0] new_sequence
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic             [2*swmm_pkg::SMP_W-1:0] out_tdata, // [31:0] window_min, [63:32] window_max
  input  wire logic                              cfg_wr_en,
  input  wire logic        [swmm_pkg::WIN_W-1:0] cfg_wr_data
);

  swmm_pkg::swmm_state_t state_r, state_nxt;
  logic [swmm_pkg::WIN_W-1:0] wsize_r;
  logic [swmm_pkg::WIN_W-1:0] seen_r, seen_nxt;
  logic [swmm_pkg::WIN_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [2*swmm_pkg::SMP_W-1:0] out_data_r, out_data_nxt;
  logic [swmm_pkg::WIN_W-1:0] weff;
  logic [swmm_pkg::IDX_W-1:0] tap_idx;
  logic signed [swmm_pkg::SMP_W-1:0] tap_lo;
  logic signed [swmm_pkg::SMP_W-1:0] tap_hi;
  logic                       in_acc;
  logic                       out_free;

  always_comb begin
    if (wsize_r == '0) begin
      weff = swmm_pkg::WIN_W'(1);
    end else if (wsize_r > swmm_pkg::WIN_W'(swmm_pkg::WINDOW_MAX)) begin
      weff = swmm_pkg::WIN_W'(swmm_pkg::WINDOW_MAX);
    end else begin
      weff = wsize_r;
    end
  end

  assign tap_idx = swmm_pkg::IDX_W'(weff - swmm_pkg::WIN_W'(1));

  swmm_chain u_chain (
    .clk       (clk),
    .shift_en  (in_acc),
    .sample_in (in_tdata),
    .tap_idx   (tap_idx),
    .tap_lo    (tap_lo),
    .tap_hi    (tap_hi)
  );

  assign in_tready = (state_r == swmm_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      swmm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            seen_nxt = swmm_pkg::WIN_W'(1);
          end else if (seen_r < swmm_pkg::WIN_W'(swmm_pkg::WINDOW_MAX)) begin
            seen_nxt = seen_r + swmm_pkg::WIN_W'(1);
          end
          if (seen_nxt >= weff) begin
            state_nxt = swmm_pkg::ST_SWEEP;
            cnt_nxt   = '0;
          end
        end
      end
      swmm_pkg::ST_SWEEP: begin
        if (cnt_r != weff) begin
          cnt_nxt = cnt_r + swmm_pkg::WIN_W'(1);
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {tap_hi, tap_lo};
          state_nxt     = swmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swmm_pkg::ST_IDLE;
      cnt_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      wsize_r     <= swmm_pkg::WIN_W'(1);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        wsize_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
